### hw/rtl/sxe_pkg.sv
// Shared types and constants for the stack expression evaluator.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package sxe_pkg;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   localparam int FLAG_UNDER = 0;
   localparam int FLAG_OVER  = 1;
   localparam int FLAG_DIV   = 2;
   localparam int FLAG_BAD   = 3;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_LOOK = 9'b000000010,
      ST_POP2 = 9'b000000100,
      ST_GET2 = 9'b000001000,
      ST_EXEC = 9'b000010000,
      ST_DIVW = 9'b000100000,
      ST_PUSH = 9'b001000000,
      ST_FPOP = 9'b010000000,
      ST_EMIT = 9'b100000000
   } state_type;

   typedef struct packed {
      logic load;
      logic pop;
      logic take_first;
      logic take_second;
      logic exec;
      logic take_quo;
      logic push;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_digit;
      logic last;
      logic div_go;
      logic div_done;
      logic rsp_free;
   } status_type;

endpackage

### hw/rtl/sxe_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing; used by sxe_dpath.
`timescale 1ns / 1ps

module sxe_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dsr_ff, dsr_in;
   logic        neg_ff, neg_in;
   logic [32:0] rem_sh;
   logic [32:0] diff;

   assign rem_sh = {rem_ff, quo_ff[31]};
   assign diff   = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[31] ? (32'd0 - dividend) : dividend;
         dsr_in  = divisor[31] ? (32'd0 - divisor) : divisor;
         neg_in  = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

endmodule

### hw/rtl/sxe_dpath.sv
// Datapath: operand stack memory, count, sticky flags, ALU, mode register, result register.
// Depends on sxe_pkg and sxe_div.
`timescale 1ns / 1ps

module sxe_dpath #(
   parameter int STACK_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  sxe_pkg::cmd_type    cmd,
   output sxe_pkg::status_type status,
   input  logic               csr_write,
   input  logic               csr_data,
   input  logic [7:0]         req_symbol,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic               rsp_underflow,
   output logic               rsp_overflow,
   output logic               rsp_divide_by_zero,
   output logic               rsp_bad_symbol
);

   import sxe_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [31:0]   mem [STACK_DEPTH];
   logic [7:0]    sym_ff;
   logic          last_ff;
   logic          mode_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [3:0]    flags_ff, flags_in;
   logic [31:0]   rd_ff;
   logic          empty_ff;
   logic [31:0]   first_ff, second_ff;
   logic [31:0]   res_ff, res_in;
   logic          rsp_valid_ff;
   logic [31:0]   rsp_value_ff;
   logic [3:0]    rsp_flags_ff;

   logic [CW-1:0] cnt_dec;
   logic          is_empty, is_full, is_digit;
   logic [31:0]   popped, lhs, rhs, push_val;
   logic [31:0]   prod_lo;
   logic          div_go, div_done;
   logic [31:0]   div_quo;

   assign cnt_dec   = count_ff - CW'(1);
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff >= CW'(STACK_DEPTH));
   assign is_digit  = (sym_ff >= CHAR_ZERO) && (sym_ff <= CHAR_NINE);
   assign popped    = empty_ff ? 32'd0 : rd_ff;
   assign lhs       = mode_ff ? first_ff : second_ff;
   assign rhs       = mode_ff ? second_ff : first_ff;
   assign prod_lo   = lhs * rhs;
   assign push_val  = is_digit ? 32'(sym_ff - CHAR_ZERO) : res_ff;
   assign div_go    = (sym_ff == CHAR_SLASH) && (rhs != 32'd0);

   sxe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.exec && div_go),
      .dividend (lhs),
      .divisor  (rhs),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      count_in = count_ff;
      flags_in = flags_ff;
      res_in   = res_ff;
      if (cmd.pop) begin
         if (is_empty) flags_in[FLAG_UNDER] = 1'b1;
         else count_in = cnt_dec;
      end
      if (cmd.push) begin
         if (is_full) flags_in[FLAG_OVER] = 1'b1;
         else count_in = count_ff + CW'(1);
      end
      if (cmd.exec) begin
         case (sym_ff)
            CHAR_PLUS:  res_in = lhs + rhs;
            CHAR_MINUS: res_in = lhs - rhs;
            CHAR_STAR:  res_in = prod_lo;
            CHAR_SLASH: begin
               res_in = 32'd0;
               if (rhs == 32'd0) flags_in[FLAG_DIV] = 1'b1;
            end
            default: begin
               res_in = 32'd0;
               flags_in[FLAG_BAD] = 1'b1;
            end
         endcase
      end
      if (cmd.take_quo) res_in = div_quo;
      if (cmd.emit) begin
         count_in = '0;
         flags_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push && !is_full) mem[count_ff[AW-1:0]] <= push_val;
      if (cmd.pop && !is_empty) rd_ff <= mem[cnt_dec[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         count_ff     <= '0;
         flags_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) mode_ff <= csr_data;
         count_ff <= count_in;
         flags_ff <= flags_in;
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
      if (cmd.load) begin
         sym_ff  <= req_symbol;
         last_ff <= req_last;
      end
      if (cmd.pop) empty_ff <= is_empty;
      if (cmd.take_first) first_ff <= popped;
      if (cmd.take_second) second_ff <= popped;
      res_ff <= res_in;
      if (cmd.emit) begin
         rsp_value_ff <= popped;
         rsp_flags_ff <= flags_ff;
      end
   end

   assign status.is_digit = is_digit;
   assign status.last     = last_ff;
   assign status.div_go   = div_go;
   assign status.div_done = div_done;
   assign status.rsp_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = rsp_value_ff;
   assign rsp_underflow      = rsp_flags_ff[FLAG_UNDER];
   assign rsp_overflow       = rsp_flags_ff[FLAG_OVER];
   assign rsp_divide_by_zero = rsp_flags_ff[FLAG_DIV];
   assign rsp_bad_symbol     = rsp_flags_ff[FLAG_BAD];

endmodule

### hw/rtl/sxe_ctrl.sv
// Controller state machine: sequences pops, execute, push and result emit.
// Depends on sxe_pkg.
`timescale 1ns / 1ps

module sxe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sxe_pkg::status_type status,
   output sxe_pkg::cmd_type    cmd
);

   import sxe_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (status.is_digit) begin
               cmd.push = 1'b1;
               state_in = status.last ? ST_FPOP : ST_IDLE;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_POP2;
            end
         end
         ST_POP2: begin
            cmd.take_first = 1'b1;
            cmd.pop        = 1'b1;
            state_in       = ST_GET2;
         end
         ST_GET2: begin
            cmd.take_second = 1'b1;
            state_in        = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = status.div_go ? ST_DIVW : ST_PUSH;
         end
         ST_DIVW: begin
            if (status.div_done) begin
               cmd.take_quo = 1'b1;
               state_in     = ST_PUSH;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = status.last ? ST_FPOP : ST_IDLE;
         end
         ST_FPOP: begin
            cmd.pop  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

### hw/rtl/stack_expression_evaluator.sv
// Top level of the stack expression evaluator: controller plus datapath.
// Depends on sxe_pkg, sxe_ctrl, sxe_dpath (which holds sxe_div).
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_symbol[7:0], req_last
//   rsp      out        rsp_valid/rsp_stall   rsp_value[31:0], four sticky flags
//   csr      in         csr_write             csr_data (prefix mode)
//
// A digit is loaded and pushed; an operator pops two operands, executes and
// pushes, and a division waits on the iterative divider, one quotient bit
// per cycle. The final character pops the result and waits for rsp_free.
// Reset is synchronous and active high; it empties the stack and clears flags.
// A stalled result holds in its register while the next request is taken.
`timescale 1ns / 1ps

module stack_expression_evaluator #(
   parameter int STACK_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_symbol,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value,
   output logic               rsp_underflow,
   output logic               rsp_overflow,
   output logic               rsp_divide_by_zero,
   output logic               rsp_bad_symbol,
   input  logic               csr_write,
   input  logic               csr_data
);

   import sxe_pkg::*;

   cmd_type    cmd;
   status_type status;

   sxe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sxe_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_write),
      .csr_data           (csr_data),
      .req_symbol         (req_symbol),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_value          (rsp_value),
      .rsp_underflow      (rsp_underflow),
      .rsp_overflow       (rsp_overflow),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .rsp_bad_symbol     (rsp_bad_symbol)
   );

`ifndef NO_ASSERTIONS
   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.rsp_free)
      else $error("result emitted over a pending result");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("emitted result not presented");

   a_stack_ops_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.push, cmd.pop, cmd.emit}))
      else $error("push, pop and emit overlap");

   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (req_valid && !req_stall))
      else $error("request loaded without acceptance");
`endif

endmodule

### dv/stack_expression_evaluator_test.sv
// Self-checking testbench for the stack expression evaluator (postfix / prefix).
// Drives a directed table, then random expressions under random idling, and
// checks results against the table or a behavioral predictor; depends on sxe_pkg.
`timescale 1ns / 1ps

module stack_expression_evaluator_test;
   import sxe_pkg::*;

   localparam int STACK_DEPTH   = 64;
   localparam int DRAIN_CYCLES  = 64;
   localparam int QUIET_LIMIT   = 4000;
   localparam int PHASES        = 5;
   localparam int PHASE_ITEMS   = 250;
   localparam int DIRECTED_ROWS = 25;

   localparam logic [3:0] F_NONE  = 4'b0000;
   localparam logic [3:0] F_UNDER = 4'b0001 << FLAG_UNDER;
   localparam logic [3:0] F_DIV   = 4'b0001 << FLAG_DIV;
   localparam logic [3:0] F_BAD   = 4'b0001 << FLAG_BAD;

   typedef enum logic {ROW_REQUEST, ROW_MODE} row_kind_type;

   typedef struct packed {
      logic [31:0] value;
      logic [3:0]  flags;
   } eval_result_type;

   typedef struct packed {
      row_kind_type    kind;
      logic            mode;
      logic [7:0]      symbol;
      logic            last;
      logic            has_expected;
      eval_result_type expected;
   } stim_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_symbol = '0;
   logic               req_last = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_value;
   logic               rsp_underflow;
   logic               rsp_overflow;
   logic               rsp_divide_by_zero;
   logic               rsp_bad_symbol;
   logic               csr_write = 1'b0;
   logic               csr_data = 1'b0;

   logic               req_has_expected = 1'b0;
   eval_result_type    req_expected = '0;

   logic [31:0]     stack_image [STACK_DEPTH];
   int unsigned     stack_fill = 0;
   logic [3:0]      sticky_flags = '0;
   logic            prefix_setting = 1'b0;
   eval_result_type expected_results [$];

   stim_type directed_table [DIRECTED_ROWS];
   stim_type script [$];
   logic  phase_mode = 1'b0;
   bit    steady = 1'b0;
   int    failures = 0;
   int    quiet_cycles = 0;
   int    stall_left = 0;

   stack_expression_evaluator #(.STACK_DEPTH(STACK_DEPTH)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_symbol         (req_symbol),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_value          (rsp_value),
      .rsp_underflow      (rsp_underflow),
      .rsp_overflow       (rsp_overflow),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .rsp_bad_symbol     (rsp_bad_symbol),
      .csr_write          (csr_write),
      .csr_data           (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] pop_operand();
      if (stack_fill == 0) begin
         sticky_flags[FLAG_UNDER] = 1'b1;
         return '0;
      end
      stack_fill--;
      return stack_image[stack_fill];
   endfunction

   function automatic void push_operand(logic [31:0] operand);
      if (stack_fill >= STACK_DEPTH) begin
         sticky_flags[FLAG_OVER] = 1'b1;
         return;
      end
      stack_image[stack_fill] = operand;
      stack_fill++;
   endfunction

   function automatic logic [31:0] truncated_quotient(logic [31:0] dividend,
                                                      logic [31:0] divisor);
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      logic [31:0] quo;
      mag_a = dividend[31] ? 32'd0 - dividend : dividend;
      mag_b = divisor[31] ? 32'd0 - divisor : divisor;
      quo = mag_a / mag_b;
      return (dividend[31] != divisor[31]) ? 32'd0 - quo : quo;
   endfunction

   function automatic bit evaluate_symbol(input logic [7:0] sym, input logic fin,
                                          output eval_result_type outcome);
      logic [31:0] top_operand;
      logic [31:0] next_operand;
      logic [31:0] lhs;
      logic [31:0] rhs;
      logic [31:0] acc;
      outcome = '0;
      if (sym >= CHAR_ZERO && sym <= CHAR_NINE) begin
         push_operand(32'(sym - CHAR_ZERO));
      end else begin
         top_operand = pop_operand();
         next_operand = pop_operand();
         lhs = prefix_setting ? top_operand : next_operand;
         rhs = prefix_setting ? next_operand : top_operand;
         acc = '0;
         case (sym)
            CHAR_PLUS: begin
               acc = lhs + rhs;
            end
            CHAR_MINUS: begin
               acc = lhs - rhs;
            end
            CHAR_STAR: begin
               acc = lhs * rhs;
            end
            CHAR_SLASH: begin
               if (rhs == 0) sticky_flags[FLAG_DIV] = 1'b1;
               else acc = truncated_quotient(lhs, rhs);
            end
            default: begin
               sticky_flags[FLAG_BAD] = 1'b1;
            end
         endcase
         push_operand(acc);
      end
      if (!fin) return 1'b0;
      outcome.value = pop_operand();
      outcome.flags = sticky_flags;
      stack_fill = 0;
      sticky_flags = '0;
      return 1'b1;
   endfunction

   // --------------------------------------------------------------- checking

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", field, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : scoreboard
      eval_result_type predicted;
      eval_result_type oldest;
      bit              produced;
      if (reset) begin
         stack_fill = 0;
         sticky_flags = '0;
         prefix_setting = 1'b0;
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (csr_write) prefix_setting = csr_data;
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            if (expected_results.size() == 0) begin
               $error("unexpected result: value %0h", rsp_value);
               failures++;
            end else begin
               oldest = expected_results.pop_front();
               check_field("value", oldest.value, rsp_value);
               check_field("underflow", 32'(oldest.flags[FLAG_UNDER]), 32'(rsp_underflow));
               check_field("overflow", 32'(oldest.flags[FLAG_OVER]), 32'(rsp_overflow));
               check_field("divide_by_zero", 32'(oldest.flags[FLAG_DIV]),
                           32'(rsp_divide_by_zero));
               check_field("bad_symbol", 32'(oldest.flags[FLAG_BAD]), 32'(rsp_bad_symbol));
            end
         end
         if (req_valid && !req_stall) begin
            quiet_cycles = 0;
            produced = evaluate_symbol(req_symbol, req_last, predicted);
            if (produced) expected_results.push_back(req_has_expected ? req_expected : predicted);
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // hold stall in bursts of random length
   always @(posedge clock) begin
      if (reset || steady) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if ($urandom_range(4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(3);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // --------------------------------------------------------------- stimulus

   function automatic stim_type req_row(logic [7:0] sym, logic fin);
      stim_type r;
      r = '0;
      r.kind = ROW_REQUEST;
      r.symbol = sym;
      r.last = fin;
      return r;
   endfunction

   function automatic stim_type known_row(logic [7:0] sym, logic [31:0] value, logic [3:0] flags);
      stim_type r;
      r = req_row(sym, 1'b1);
      r.has_expected = 1'b1;
      r.expected.value = value;
      r.expected.flags = flags;
      return r;
   endfunction

   function automatic stim_type mode_row(logic mode);
      stim_type r;
      r = '0;
      r.kind = ROW_MODE;
      r.mode = mode;
      return r;
   endfunction

   task automatic send_request(stim_type r);
      if (!steady && $urandom_range(3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_symbol <= r.symbol;
      req_last <= r.last;
      req_has_expected <= r.has_expected;
      req_expected <= r.expected;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drain all results, let a result-less request finish, then write the mode
   task automatic write_mode(logic mode);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write <= 1'b1;
      csr_data <= mode;
      @(posedge clock);
      csr_write <= 1'b0;
      phase_mode = mode;
   endtask

   function automatic logic [7:0] random_operator();
      case ($urandom_range(3))
         0: return CHAR_PLUS;
         1: return CHAR_MINUS;
         2: return CHAR_STAR;
         default: return CHAR_SLASH;
      endcase
   endfunction

   function automatic logic [7:0] random_digit();
      return CHAR_ZERO + 8'($urandom_range(9));
   endfunction

   task automatic add_symbol(logic [7:0] sym, logic fin);
      script.push_back(req_row(sym, fin));
   endtask

   task automatic mark_last();
      stim_type tail;
      tail = script.pop_back();
      tail.last = 1'b1;
      script.push_back(tail);
   endtask

   task automatic add_expression(int target, bit broken);
      int depth;
      int count;
      logic [7:0] sym;
      depth = 0;
      count = 0;
      while (count < target || depth != 1) begin
         if (depth < 2 || (count < target && depth < 8 && $urandom_range(1) == 0)) begin
            sym = random_digit();
            depth++;
         end else begin
            sym = random_operator();
            depth--;
         end
         if (broken && $urandom_range(5) == 0) sym = 8'($urandom_range(255));
         add_symbol(sym, 1'b0);
         count++;
      end
      mark_last();
   endtask

   task automatic add_overflow();
      repeat (STACK_DEPTH + $urandom_range(1, 4)) add_symbol(random_digit(), 1'b0);
      repeat (STACK_DEPTH - 1) add_symbol($urandom_range(1) ? CHAR_PLUS : CHAR_STAR, 1'b0);
      mark_last();
   endtask

   task automatic add_minus_one();
      add_symbol(phase_mode ? CHAR_ZERO + 8'd1 : CHAR_ZERO, 1'b0);
      add_symbol(phase_mode ? CHAR_ZERO : CHAR_ZERO + 8'd1, 1'b0);
      add_symbol(CHAR_MINUS, 1'b0);
   endtask

   // 2 * 8^10 wraps to the most negative value; combine it with minus one, mostly by division
   task automatic add_min_by_minus_one();
      if (phase_mode) add_minus_one();
      add_symbol(CHAR_ZERO + 8'd2, 1'b0);
      repeat (10) begin
         add_symbol(CHAR_ZERO + 8'd8, 1'b0);
         add_symbol(CHAR_STAR, 1'b0);
      end
      if (!phase_mode) add_minus_one();
      add_symbol($urandom_range(3) == 0 ? random_operator() : CHAR_SLASH, 1'b1);
   endtask

   task automatic add_noise();
      repeat ($urandom_range(0, 5)) add_symbol(8'($urandom_range(255)), $urandom_range(2) == 0);
      add_symbol(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic build_sequence();
      int pick;
      pick = $urandom_range(99);
      if (pick < 2) add_overflow();
      else if (pick < 8) add_min_by_minus_one();
      else if (pick < 78) add_expression($urandom_range(1, 15), 1'b0);
      else if (pick < 88) add_expression($urandom_range(1, 15), 1'b1);
      else add_noise();
   endtask

   initial begin
      int sent;
      directed_table = '{
         known_row(CHAR_ZERO, 32'd0, F_NONE),
         known_row(CHAR_NINE, 32'd9, F_NONE),
         known_row(CHAR_PLUS, 32'd0, F_UNDER),
         req_row(CHAR_NINE, 1'b0),
         req_row(CHAR_ZERO + 8'd8, 1'b0),
         req_row(CHAR_MINUS, 1'b1),
         req_row(CHAR_ZERO + 8'd5, 1'b0),
         req_row(CHAR_ZERO, 1'b0),
         known_row(CHAR_SLASH, 32'd0, F_DIV),
         known_row(CHAR_NINE + 8'd1, 32'd0, F_UNDER | F_BAD),
         known_row(8'hFF, 32'd0, F_UNDER | F_BAD),
         known_row(8'h00, 32'd0, F_UNDER | F_BAD),
         req_row(CHAR_ZERO + 8'd4, 1'b0),
         req_row(CHAR_ZERO + 8'd6, 1'b0),
         req_row(CHAR_STAR, 1'b1),
         req_row(CHAR_ZERO + 8'd7, 1'b0),
         req_row(CHAR_ZERO + 8'd3, 1'b0),
         mode_row(1'b1),
         req_row(CHAR_SLASH, 1'b1),
         req_row(CHAR_ZERO + 8'd2, 1'b0),
         req_row(CHAR_NINE, 1'b0),
         req_row(CHAR_MINUS, 1'b1),
         req_row(CHAR_ZERO + 8'd1, 1'b0),
         req_row(CHAR_STAR, 1'b1),
         mode_row(1'b0)
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed_table[i].kind == ROW_MODE) write_mode(directed_table[i].mode);
         else send_request(directed_table[i]);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         steady = (phase == PHASES - 1);
         write_mode(phase < 2 ? phase[0] : 1'($urandom_range(1)));
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            build_sequence();
            sent += script.size();
            foreach (script[k]) send_request(script[k]);
            script.delete();
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
hw/rtl/sxe_pkg.sv
hw/rtl/sxe_div.sv
hw/rtl/sxe_dpath.sv
hw/rtl/sxe_ctrl.sv
hw/rtl/stack_expression_evaluator.sv
dv/stack_expression_evaluator_test.sv
